// ===== design/psplit_pkg.sv =====
// shared types and constants for the packet split point finder
// no dependencies; imported by packet_split_point_finder_unit
`default_nettype none

package psplit_pkg;

  // longest packet that is looked at, bytes beyond it are ignored
  localparam int unsigned MAX_PACKET = 65535;
  // byte counter holds 0 .. MAX_PACKET
  localparam int unsigned CNT_W = $clog2(MAX_PACKET + 1);
  // field positions reach MAX_PACKET plus a full 16-bit length
  localparam int unsigned POS_W = $clog2(MAX_PACKET + 65536);

  // input transaction
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic [1:0] protocol_hint;
  } byte_item_t;

  // result transaction
  typedef struct packed {
    logic [15:0] split_offset;
    logic [1:0]  protocol_used;
    logic [1:0]  split_source;
  } split_result_t;

  // tls clienthello walk phases
  typedef enum logic [3:0] {
    PH_REC,
    PH_HS,
    PH_SID,
    PH_CS_HI,
    PH_CS_LO,
    PH_CM,
    PH_EXT_HI,
    PH_EXT_LO,
    PH_TYPE_HI,
    PH_TYPE_LO,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_IDLE
  } parse_phase_t;

  // protocol codes
  localparam logic [1:0] PROTO_UNKNOWN = 2'd0;
  localparam logic [1:0] PROTO_TLS     = 2'd1;
  localparam logic [1:0] PROTO_HTTP    = 2'd2;

  // split source codes
  localparam logic [1:0] SRC_SNI      = 2'd0;
  localparam logic [1:0] SRC_HOST     = 2'd1;
  localparam logic [1:0] SRC_FALLBACK = 2'd2;

  // tls layout
  localparam logic [7:0]  REC_HANDSHAKE   = 8'h16;
  localparam logic [7:0]  HS_CLIENT_HELLO = 8'h01;
  localparam logic [15:0] SNI_EXT_TYPE    = 16'h0000;
  localparam logic [7:0]  REC_TYPE_LOW    = 8'h14;
  localparam logic [7:0]  REC_TYPE_HIGH   = 8'h18;
  localparam logic [7:0]  REC_MAJOR       = 8'h03;
  localparam int unsigned HS_TYPE_POS     = 5;
  localparam int unsigned SID_POS         = 43;
  localparam int unsigned TLS_FALLBACK    = 6;

  // http method words and host header letters
  localparam logic [31:0] METHOD_GET  = 32'h4745_5420;
  localparam logic [31:0] METHOD_POST = 32'h504F_5354;
  localparam logic [31:0] METHOD_HEAD = 32'h4845_4144;
  localparam logic [31:0] METHOD_PUT  = 32'h5055_5420;
  localparam logic [7:0]  CASE_BIT    = 8'h20;
  localparam logic [7:0]  CHAR_H      = 8'h68;
  localparam logic [7:0]  CHAR_O      = 8'h6F;
  localparam logic [7:0]  CHAR_S      = 8'h73;
  localparam logic [7:0]  CHAR_T      = 8'h74;
  localparam logic [7:0]  CHAR_COLON  = 8'h3A;

  // fallback register reset value
  localparam logic [15:0] DEFAULT_SPLIT_RST = 16'd2;

endpackage

`default_nettype wire

// ===== design/packet_split_point_finder_unit.sv =====
// packet split point finder: tls sni / http host locator, one byte per cycle while byte_stall is low
// depends on psplit_pkg (types, phase enum, protocol constants)
`default_nettype none

//  channel   handshake                   payload
//  byte      byte_valid / byte_stall     byte_item (byte_item_t)
//  result    result_valid / result_stall result_item (split_result_t)
//  config    cfg_write                   cfg_wdata (default_split)
//
// one byte is taken each cycle while byte_stall is low; the parse state is
// updated in the same cycle the byte is taken. the result of a last byte is
// registered into result_item, or into the skid register while result_item
// is held by result_stall; this one-entry skid register lets the byte side
// keep flowing while a result waits; byte_stall rises only when both are full.
// synchronous reset clears the packet state and sets default_split to 2.

module packet_split_point_finder_unit
  import psplit_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          byte_valid,
  output logic               byte_stall,
  input  wire byte_item_t    byte_item,
  output logic               result_valid,
  input  wire logic          result_stall,
  output split_result_t      result_item,
  input  wire logic          cfg_write,
  input  wire logic [15:0]   cfg_wdata
);

  // configuration
  logic [15:0] default_split;

  // packet state
  logic [CNT_W-1:0] byte_count;
  parse_phase_t     parse_phase;
  logic [POS_W-1:0] next_field_pos;
  logic [POS_W-1:0] extensions_end;
  logic [7:0]       field_accum;
  logic [31:0]      head_bytes;
  logic [31:0]      window_bytes;
  logic [CNT_W-1:0] sni_pos;
  logic             sni_found;
  logic [CNT_W-1:0] host_pos;
  logic             host_found;
  logic [1:0]       latched_protocol;

  logic [CNT_W-1:0] byte_count_next;
  parse_phase_t     parse_phase_next;
  logic [POS_W-1:0] next_field_pos_next;
  logic [POS_W-1:0] extensions_end_next;
  logic [7:0]       field_accum_next;
  logic [31:0]      head_bytes_next;
  logic [31:0]      window_bytes_next;
  logic [CNT_W-1:0] sni_pos_next;
  logic             sni_found_next;
  logic [CNT_W-1:0] host_pos_next;
  logic             host_found_next;
  logic [1:0]       latched_protocol_next;

  // output buffering
  split_result_t skid_item;
  logic          skid_valid;
  split_result_t result_new;

  logic             take;
  logic             emit;
  logic [7:0]       b;
  logic [POS_W-1:0] pos;
  logic             host_hit;

  assign byte_stall = skid_valid;
  assign take       = byte_valid && !skid_valid;
  assign emit       = take && byte_item.last_byte;
  assign b          = byte_item.data_byte;
  assign pos        = POS_W'(byte_count);

  // host header match on the last four bytes plus this one
  assign host_hit = ((window_bytes[31:24] | CASE_BIT) == CHAR_H)
                 && ((window_bytes[23:16] | CASE_BIT) == CHAR_O)
                 && ((window_bytes[15:8]  | CASE_BIT) == CHAR_S)
                 && ((window_bytes[7:0]   | CASE_BIT) == CHAR_T)
                 && (b == CHAR_COLON);

  // per-byte state update
  always_comb begin
    byte_count_next       = byte_count;
    parse_phase_next      = parse_phase;
    next_field_pos_next   = next_field_pos;
    extensions_end_next   = extensions_end;
    field_accum_next      = field_accum;
    head_bytes_next       = head_bytes;
    window_bytes_next     = window_bytes;
    sni_pos_next          = sni_pos;
    sni_found_next        = sni_found;
    host_pos_next         = host_pos;
    host_found_next       = host_found;
    latched_protocol_next = latched_protocol;
    if (take) begin
      if (byte_count == '0) begin
        latched_protocol_next = byte_item.protocol_hint;
      end
      if (byte_count < CNT_W'(MAX_PACKET)) begin
        // clienthello walk
        case (parse_phase)
          PH_REC: begin
            parse_phase_next = (byte_count == '0 && b == REC_HANDSHAKE) ? PH_HS : PH_IDLE;
          end
          PH_HS: begin
            if (byte_count == CNT_W'(HS_TYPE_POS)) begin
              if (b == HS_CLIENT_HELLO) begin
                next_field_pos_next = POS_W'(SID_POS);
                parse_phase_next    = PH_SID;
              end else begin
                parse_phase_next = PH_IDLE;
              end
            end
          end
          PH_SID: begin
            if (pos == next_field_pos) begin
              next_field_pos_next = pos + POS_W'(1) + POS_W'(b);
              parse_phase_next    = PH_CS_HI;
            end
          end
          PH_CS_HI: begin
            if (pos == next_field_pos) begin
              field_accum_next = b;
              parse_phase_next = PH_CS_LO;
            end
          end
          PH_CS_LO: begin
            next_field_pos_next = pos + POS_W'(1) + POS_W'({field_accum, b});
            parse_phase_next    = PH_CM;
          end
          PH_CM: begin
            if (pos == next_field_pos) begin
              next_field_pos_next = pos + POS_W'(1) + POS_W'(b);
              parse_phase_next    = PH_EXT_HI;
            end
          end
          PH_EXT_HI: begin
            if (pos == next_field_pos) begin
              field_accum_next = b;
              parse_phase_next = PH_EXT_LO;
            end
          end
          PH_EXT_LO: begin
            next_field_pos_next = pos + POS_W'(1);
            extensions_end_next = pos + POS_W'(1) + POS_W'({field_accum, b});
            parse_phase_next    = PH_TYPE_HI;
          end
          PH_TYPE_HI: begin
            if (pos == next_field_pos) begin
              if (({1'b0, next_field_pos} + (POS_W+1)'(4)) > {1'b0, extensions_end}) begin
                parse_phase_next = PH_IDLE;
              end else begin
                field_accum_next = b;
                parse_phase_next = PH_TYPE_LO;
              end
            end
          end
          PH_TYPE_LO: begin
            if ({field_accum, b} == SNI_EXT_TYPE) begin
              sni_pos_next     = byte_count - CNT_W'(1);
              sni_found_next   = 1'b1;
              parse_phase_next = PH_IDLE;
            end else begin
              parse_phase_next = PH_LEN_HI;
            end
          end
          PH_LEN_HI: begin
            field_accum_next = b;
            parse_phase_next = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            next_field_pos_next = pos + POS_W'(1) + POS_W'({field_accum, b});
            parse_phase_next    = PH_TYPE_HI;
          end
          default: begin
            parse_phase_next = PH_IDLE;
          end
        endcase
        // first host header
        if (byte_count >= CNT_W'(4) && !host_found && host_hit) begin
          host_found_next = 1'b1;
          host_pos_next   = byte_count - CNT_W'(4);
        end
        // opening bytes and sliding window
        if (byte_count < CNT_W'(4)) begin
          head_bytes_next[{~byte_count[1:0], 3'b000} +: 8] = b;
        end
        window_bytes_next = {window_bytes[23:0], b};
        byte_count_next   = byte_count + CNT_W'(1);
      end
    end
  end

  // split decision on the updated state
  logic [CNT_W-1:0] len;
  logic [7:0]       b0;
  logic [7:0]       b1;
  logic [1:0]       detected;
  logic [1:0]       proto;

  assign len = byte_count_next;
  assign b0  = head_bytes_next[31:24];
  assign b1  = head_bytes_next[23:16];

  always_comb begin
    detected = PROTO_UNKNOWN;
    if (len >= CNT_W'(3)) begin
      if (b0 >= REC_TYPE_LOW && b0 <= REC_TYPE_HIGH && b1 == REC_MAJOR) begin
        detected = PROTO_TLS;
      end else if (len >= CNT_W'(4) &&
                   (head_bytes_next == METHOD_GET || head_bytes_next == METHOD_POST ||
                    head_bytes_next == METHOD_HEAD || head_bytes_next == METHOD_PUT)) begin
        detected = PROTO_HTTP;
      end
    end
  end

  assign proto = (latched_protocol_next != PROTO_UNKNOWN) ? latched_protocol_next : detected;

  always_comb begin
    result_new.protocol_used = proto;
    result_new.split_source  = SRC_FALLBACK;
    result_new.split_offset  = default_split;
    case (proto)
      PROTO_TLS: begin
        if (sni_found_next &&
            ({1'b0, sni_pos_next} + (CNT_W+1)'(4)) <= {1'b0, len}) begin
          result_new.split_offset = 16'(sni_pos_next);
          result_new.split_source = SRC_SNI;
        end else if (len < CNT_W'(TLS_FALLBACK)) begin
          result_new.split_offset = 16'(len);
        end else begin
          result_new.split_offset = 16'(TLS_FALLBACK);
        end
      end
      PROTO_HTTP: begin
        if (host_found_next && host_pos_next != '0) begin
          result_new.split_offset = 16'(host_pos_next) + 16'd3;
          result_new.split_source = SRC_HOST;
        end
      end
      default: begin
        if (default_split >= 16'(len)) begin
          result_new.split_offset = 16'(len);
        end
      end
    endcase
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      default_split <= DEFAULT_SPLIT_RST;
    end else if (cfg_write) begin
      default_split <= cfg_wdata;
    end
  end

  // packet state, cleared after the last byte
  always_ff @(posedge clk) begin
    if (rst || emit) begin
      byte_count       <= '0;
      parse_phase      <= PH_REC;
      next_field_pos   <= '0;
      extensions_end   <= '0;
      field_accum      <= '0;
      head_bytes       <= '0;
      window_bytes     <= '0;
      sni_pos          <= '0;
      sni_found        <= 1'b0;
      host_pos         <= '0;
      host_found       <= 1'b0;
      latched_protocol <= PROTO_UNKNOWN;
    end else begin
      byte_count       <= byte_count_next;
      parse_phase      <= parse_phase_next;
      next_field_pos   <= next_field_pos_next;
      extensions_end   <= extensions_end_next;
      field_accum      <= field_accum_next;
      head_bytes       <= head_bytes_next;
      window_bytes     <= window_bytes_next;
      sni_pos          <= sni_pos_next;
      sni_found        <= sni_found_next;
      host_pos         <= host_pos_next;
      host_found       <= host_found_next;
      latched_protocol <= latched_protocol_next;
    end
  end

  // result register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || !result_stall) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= emit;
      end
    end else if (emit) begin
      skid_valid <= 1'b1;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (!result_valid || !result_stall) begin
      if (skid_valid) begin
        result_item <= skid_item;
      end else if (emit) begin
        result_item <= result_new;
      end
    end else if (emit) begin
      skid_item <= result_new;
    end
  end

endmodule

`default_nettype wire
